// File: rtl/pdp_pkg.sv
// ----------------------------------------------------------------------------
// pdp_pkg: shared types and constants of the PLL divider planner
// Widths, band limits, codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pdp_pkg;

    localparam int FREQ_W     = 32;
    localparam int PFD_W      = 28;
    localparam int VCO_W      = 33;
    localparam int DEN_W      = 24;
    localparam int NINT_W     = 16;
    localparam int CDIV_W     = 9;
    localparam int DVSR_W     = PFD_W + 2;
    localparam int PROD_W     = FREQ_W + CDIV_W;
    localparam int MULF_W     = DVSR_W + DEN_W;
    localparam int DIV_NUM_W  = MULF_W;
    localparam int DIV_DEN_W  = FREQ_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VCO_W;

    localparam logic [FREQ_W-1:0] TX_BAND_LO = 32'd30000000;
    localparam logic [FREQ_W-1:0] TX_BAND_HI = 32'd108000000;
    localparam logic [FREQ_W-1:0] RX_BAND_LO = 32'd285000000;
    localparam logic [FREQ_W-1:0] RX_BAND_HI = 32'd363000000;

    localparam logic [NINT_W-1:0] N_INT_MAX = 16'hFFFF;

    localparam logic [1:0] C1_LAST = 2'd3;
    localparam logic [2:0] K_LAST  = 3'd6;

    localparam logic [PFD_W-1:0] RST_TX_PFD   = 28'd50000000;
    localparam logic [PFD_W-1:0] RST_RX_PFD   = 28'd80000000;
    localparam logic             RST_TX_BY4   = 1'b1;
    localparam logic             RST_RX_BY4   = 1'b0;
    localparam logic [VCO_W-1:0] RST_VCO_MIN  = 33'd4300000000;
    localparam logic [VCO_W-1:0] RST_VCO_MAX  = 33'd5376000000;
    localparam logic [DEN_W-1:0] RST_FRAC_DEN = 24'd10000000;

    localparam logic [CFG_IDX_W-1:0] REG_TX_PFD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RX_PFD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TX_BY4   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RX_BY4   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VCO_MAX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_DEN = 3'd6;

    typedef logic [1:0] t_div_op;
    localparam t_div_op OP_VMIN = 2'd0;
    localparam t_div_op OP_VMAX = 2'd1;
    localparam t_div_op OP_NINT = 2'd2;
    localparam t_div_op OP_FRAC = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_BAND  = 2'd1;
    localparam t_status ST_NOFIT = 2'd2;
    localparam t_status ST_OVF   = 2'd3;

    typedef struct packed {
        logic    load;
        logic    div_start;
        t_div_op div_op;
        logic    div_store;
        logic    srch_step;
        logic    mul_vco;
        logic    mul_frac;
    } t_cmd;

    typedef struct packed {
        logic out_of_band;
        logic div_done;
        logic srch_last;
        logic no_fit;
        logic nint_ovf;
    } t_sts;

endpackage

// File: rtl/pll_divider_planner.sv
// ----------------------------------------------------------------------------
// pll_divider_planner: fractional-N divider planner
// Checks a requested output frequency against its path band, picks the
// largest fitting channel divider and computes integer and fractional N.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+-----------------------------------
//   request  | i_in_valid / o_in_ready    | i_func, i_freq_hz
//   result   | o_out_valid / i_out_ready  | o_status, o_n_integer, o_n_fraction,
//            |                            | o_prediv_code, o_chdiv1_code,
//            |                            | o_chdiv2_code
//   config   | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
// The four divisions share one restoring divider with a 54-bit quotient,
// and the divider search tries each channel divider candidate in turn. An
// out-of-band request skips the divisions and the search; one with no fitting
// divider ends after the search, and one with integer N overflow skips the fraction.
// Reset is synchronous and restores the configuration defaults.
// A finished result waits in the output register while the next request is
// transferred; the sequencer holds its last state while that register is full and not taken.
// ----------------------------------------------------------------------------
module pll_divider_planner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    input  logic [pdp_pkg::FREQ_W-1:0]          i_freq_hz,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic [pdp_pkg::NINT_W-1:0]          o_n_integer,
    output logic [pdp_pkg::DEN_W-1:0]           o_n_fraction,
    output logic                                o_prediv_code,
    output logic [1:0]                          o_chdiv1_code,
    output logic [2:0]                          o_chdiv2_code,
    input  logic                                i_cfg_we,
    input  logic [pdp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pdp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    logic [pdp_pkg::PFD_W-1:0]   r_tx_pfd;
    logic [pdp_pkg::PFD_W-1:0]   r_rx_pfd;
    logic                        r_tx_by4;
    logic                        r_rx_by4;
    logic [pdp_pkg::VCO_W-1:0]   r_vco_min;
    logic [pdp_pkg::VCO_W-1:0]   r_vco_max;
    logic [pdp_pkg::DEN_W-1:0]   r_frac_den;

    logic                        r_out_valid;
    pdp_pkg::t_status            r_status;
    logic [pdp_pkg::NINT_W-1:0]  r_n_integer;
    logic [pdp_pkg::DEN_W-1:0]   r_n_fraction;
    logic                        r_prediv_code;
    logic [1:0]                  r_chdiv1_code;
    logic [2:0]                  r_chdiv2_code;

    pdp_pkg::t_cmd               w_cmd;
    pdp_pkg::t_sts               w_sts;
    logic                        w_out_load;
    pdp_pkg::t_status            w_status;
    logic [pdp_pkg::NINT_W-1:0]  w_n_integer;
    logic [pdp_pkg::DEN_W-1:0]   w_n_fraction;
    logic                        w_prediv_code;
    logic [1:0]                  w_chdiv1_code;
    logic [2:0]                  w_chdiv2_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_pfd   <= pdp_pkg::RST_TX_PFD;
            r_rx_pfd   <= pdp_pkg::RST_RX_PFD;
            r_tx_by4   <= pdp_pkg::RST_TX_BY4;
            r_rx_by4   <= pdp_pkg::RST_RX_BY4;
            r_vco_min  <= pdp_pkg::RST_VCO_MIN;
            r_vco_max  <= pdp_pkg::RST_VCO_MAX;
            r_frac_den <= pdp_pkg::RST_FRAC_DEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdp_pkg::REG_TX_PFD:   r_tx_pfd   <= i_cfg_wdata[pdp_pkg::PFD_W-1:0];
                pdp_pkg::REG_RX_PFD:   r_rx_pfd   <= i_cfg_wdata[pdp_pkg::PFD_W-1:0];
                pdp_pkg::REG_TX_BY4:   r_tx_by4   <= i_cfg_wdata[0];
                pdp_pkg::REG_RX_BY4:   r_rx_by4   <= i_cfg_wdata[0];
                pdp_pkg::REG_VCO_MIN:  r_vco_min  <= i_cfg_wdata;
                pdp_pkg::REG_VCO_MAX:  r_vco_max  <= i_cfg_wdata;
                pdp_pkg::REG_FRAC_DEN: r_frac_den <= i_cfg_wdata[pdp_pkg::DEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_full  (r_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_load  (w_out_load),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    pdp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_func        (i_func),
        .i_freq_hz     (i_freq_hz),
        .i_tx_pfd      (r_tx_pfd),
        .i_rx_pfd      (r_rx_pfd),
        .i_tx_by4      (r_tx_by4),
        .i_rx_by4      (r_rx_by4),
        .i_vco_min     (r_vco_min),
        .i_vco_max     (r_vco_max),
        .i_frac_den    (r_frac_den),
        .o_status      (w_status),
        .o_n_integer   (w_n_integer),
        .o_n_fraction  (w_n_fraction),
        .o_prediv_code (w_prediv_code),
        .o_chdiv1_code (w_chdiv1_code),
        .o_chdiv2_code (w_chdiv2_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_status      <= w_status;
            r_n_integer   <= w_n_integer;
            r_n_fraction  <= w_n_fraction;
            r_prediv_code <= w_prediv_code;
            r_chdiv1_code <= w_chdiv1_code;
            r_chdiv2_code <= w_chdiv2_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_n_integer   = r_n_integer;
    assign o_n_fraction  = r_n_fraction;
    assign o_prediv_code = r_prediv_code;
    assign o_chdiv1_code = r_chdiv1_code;
    assign o_chdiv2_code = r_chdiv2_code;

    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in progress");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == pdp_pkg::ST_BAND || o_status == pdp_pkg::ST_NOFIT))
        |-> (o_n_integer == '0 && o_n_fraction == '0 && o_chdiv1_code == '0))
        else $error("rejected request carries nonzero fields");

    a_ovf_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == pdp_pkg::ST_OVF)
        |-> (o_n_integer == pdp_pkg::N_INT_MAX && o_n_fraction == '0))
        else $error("integer N overflow not saturated");

endmodule

// File: rtl/pdp_div.sv
// ----------------------------------------------------------------------------
// pdp_div: iterative restoring divider
// Produces one quotient bit per cycle; quotient and remainder are held
// after the done pulse until the next start.
// ----------------------------------------------------------------------------
module pdp_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quot[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// File: rtl/pdp_dp.sv
// ----------------------------------------------------------------------------
// pdp_dp: planner datapath
// Band check, divider bounds, channel divider search, feedback divider
// products and the shared divider, steered by controller commands.
// ----------------------------------------------------------------------------
module pdp_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pdp_pkg::t_cmd                   i_cmd,
    output pdp_pkg::t_sts                   o_sts,
    input  logic                            i_func,
    input  logic [pdp_pkg::FREQ_W-1:0]      i_freq_hz,
    input  logic [pdp_pkg::PFD_W-1:0]       i_tx_pfd,
    input  logic [pdp_pkg::PFD_W-1:0]       i_rx_pfd,
    input  logic                            i_tx_by4,
    input  logic                            i_rx_by4,
    input  logic [pdp_pkg::VCO_W-1:0]       i_vco_min,
    input  logic [pdp_pkg::VCO_W-1:0]       i_vco_max,
    input  logic [pdp_pkg::DEN_W-1:0]       i_frac_den,
    output pdp_pkg::t_status                o_status,
    output logic [pdp_pkg::NINT_W-1:0]      o_n_integer,
    output logic [pdp_pkg::DEN_W-1:0]       o_n_fraction,
    output logic                            o_prediv_code,
    output logic [1:0]                      o_chdiv1_code,
    output logic [2:0]                      o_chdiv2_code
);

    logic                              r_func;
    logic [pdp_pkg::FREQ_W-1:0]        r_freq;
    logic                              r_oob;
    pdp_pkg::t_div_op                  r_op;
    logic [pdp_pkg::VCO_W:0]           r_minc;
    logic [pdp_pkg::VCO_W-1:0]         r_maxc;
    logic [1:0]                        r_c1;
    logic [2:0]                        r_k;
    logic [pdp_pkg::CDIV_W-1:0]        r_best;
    logic [1:0]                        r_best_c1;
    logic [2:0]                        r_best_k;
    logic [pdp_pkg::PROD_W-1:0]        r_vco;
    logic [pdp_pkg::PROD_W-1:0]        r_nint;
    logic [pdp_pkg::DVSR_W-1:0]        r_rem;
    logic [pdp_pkg::MULF_W-1:0]        r_prod;
    logic [pdp_pkg::DEN_W-1:0]         r_frac;

    logic                              w_oob;
    logic [pdp_pkg::PFD_W-1:0]         w_pfd;
    logic                              w_by4;
    logic [pdp_pkg::DVSR_W-1:0]        w_d;
    logic [pdp_pkg::CDIV_W-1:0]        w_cand;
    logic                              w_hit;
    logic [pdp_pkg::DIV_NUM_W-1:0]     w_num;
    logic [pdp_pkg::DIV_DEN_W-1:0]     w_den;
    logic                              w_done;
    logic [pdp_pkg::DIV_NUM_W-1:0]     w_quot;
    logic [pdp_pkg::DIV_DEN_W-1:0]     w_rem;

    assign w_oob = i_func ? ((i_freq_hz < pdp_pkg::RX_BAND_LO) ||
                             (i_freq_hz > pdp_pkg::RX_BAND_HI))
                          : ((i_freq_hz < pdp_pkg::TX_BAND_LO) ||
                             (i_freq_hz > pdp_pkg::TX_BAND_HI));

    // A phase detector frequency of zero is taken as 1 Hz.
    always_comb begin
        w_pfd = r_func ? i_rx_pfd : i_tx_pfd;
        if (w_pfd == '0) begin
            w_pfd = pdp_pkg::PFD_W'(1);
        end
    end

    assign w_by4 = r_func ? i_rx_by4 : i_tx_by4;
    assign w_d   = w_by4 ? {w_pfd, 2'b00} : {1'b0, w_pfd, 1'b0};

    assign w_cand = pdp_pkg::CDIV_W'({1'b1, r_c1}) << r_k;
    assign w_hit  = ((pdp_pkg::VCO_W + 1)'(w_cand) >= r_minc) &&
                    (pdp_pkg::VCO_W'(w_cand) <= r_maxc) && (w_cand > r_best);

    always_comb begin
        unique case (i_cmd.div_op)
            pdp_pkg::OP_VMIN: begin
                w_num = pdp_pkg::DIV_NUM_W'(i_vco_min);
                w_den = pdp_pkg::DIV_DEN_W'(r_freq);
            end
            pdp_pkg::OP_VMAX: begin
                w_num = pdp_pkg::DIV_NUM_W'(i_vco_max);
                w_den = pdp_pkg::DIV_DEN_W'(r_freq);
            end
            pdp_pkg::OP_NINT: begin
                w_num = pdp_pkg::DIV_NUM_W'(r_vco);
                w_den = pdp_pkg::DIV_DEN_W'(w_d);
            end
            default: begin
                w_num = pdp_pkg::DIV_NUM_W'(r_prod);
                w_den = pdp_pkg::DIV_DEN_W'(w_d);
            end
        endcase
    end

    pdp_div #(
        .NUM_W (pdp_pkg::DIV_NUM_W),
        .DEN_W (pdp_pkg::DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_freq    <= i_freq_hz;
            r_oob     <= w_oob;
            r_c1      <= '0;
            r_k       <= '0;
            r_best    <= '0;
            r_best_c1 <= '0;
            r_best_k  <= '0;
        end else if (i_cmd.srch_step) begin
            if (w_hit) begin
                r_best    <= w_cand;
                r_best_c1 <= r_c1;
                r_best_k  <= r_k;
            end
            if (r_k == pdp_pkg::K_LAST) begin
                r_k  <= '0;
                r_c1 <= r_c1 + 1'b1;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
        if (i_cmd.div_start) begin
            r_op <= i_cmd.div_op;
        end
        if (i_cmd.div_store) begin
            unique case (r_op)
                pdp_pkg::OP_VMIN: begin
                    r_minc <= {1'b0, w_quot[pdp_pkg::VCO_W-1:0]} +
                              (pdp_pkg::VCO_W + 1)'(w_rem != '0);
                end
                pdp_pkg::OP_VMAX: begin
                    r_maxc <= w_quot[pdp_pkg::VCO_W-1:0];
                end
                pdp_pkg::OP_NINT: begin
                    r_nint <= w_quot[pdp_pkg::PROD_W-1:0];
                    r_rem  <= w_rem[pdp_pkg::DVSR_W-1:0];
                end
                default: begin
                    r_frac <= w_quot[pdp_pkg::DEN_W-1:0];
                end
            endcase
        end
        if (i_cmd.mul_vco) begin
            r_vco <= pdp_pkg::PROD_W'(r_freq) * pdp_pkg::PROD_W'(r_best);
        end
        if (i_cmd.mul_frac) begin
            r_prod <= pdp_pkg::MULF_W'(r_rem) * pdp_pkg::MULF_W'(i_frac_den);
        end
    end

    assign o_sts.out_of_band = r_oob;
    assign o_sts.div_done    = w_done;
    assign o_sts.srch_last   = (r_c1 == pdp_pkg::C1_LAST) && (r_k == pdp_pkg::K_LAST);
    assign o_sts.no_fit      = (r_best == '0);
    assign o_sts.nint_ovf    = |r_nint[pdp_pkg::PROD_W-1:pdp_pkg::NINT_W];

    always_comb begin
        o_status      = pdp_pkg::ST_OK;
        o_n_integer   = '0;
        o_n_fraction  = '0;
        o_prediv_code = 1'b0;
        o_chdiv1_code = '0;
        o_chdiv2_code = '0;
        if (r_oob) begin
            o_status = pdp_pkg::ST_BAND;
        end else if (r_best == '0) begin
            o_status = pdp_pkg::ST_NOFIT;
        end else begin
            o_prediv_code = w_by4;
            o_chdiv1_code = r_best_c1;
            o_chdiv2_code = r_best_k;
            if (o_sts.nint_ovf) begin
                o_status    = pdp_pkg::ST_OVF;
                o_n_integer = pdp_pkg::N_INT_MAX;
            end else begin
                o_n_integer  = r_nint[pdp_pkg::NINT_W-1:0];
                o_n_fraction = r_frac;
            end
        end
    end

endmodule

// File: rtl/pdp_ctrl.sv
// ----------------------------------------------------------------------------
// pdp_ctrl: planner sequencer
// Steps one item through band check, up to four divisions, the divider search
// and up to two products, then hands the result to the output register.
// ----------------------------------------------------------------------------
module pdp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_full,
    input  logic          i_out_ready,
    output logic          o_out_load,
    output pdp_pkg::t_cmd o_cmd,
    input  pdp_pkg::t_sts i_sts
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BAND    = 4'd1;
    localparam logic [3:0] S_MIN_WT  = 4'd2;
    localparam logic [3:0] S_MAX_GO  = 4'd3;
    localparam logic [3:0] S_MAX_WT  = 4'd4;
    localparam logic [3:0] S_SRCH    = 4'd5;
    localparam logic [3:0] S_FIT     = 4'd6;
    localparam logic [3:0] S_NINT_GO = 4'd7;
    localparam logic [3:0] S_NINT_WT = 4'd8;
    localparam logic [3:0] S_OVF     = 4'd9;
    localparam logic [3:0] S_FRAC_GO = 4'd10;
    localparam logic [3:0] S_FRAC_WT = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_out_load = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BAND;
                end
            end
            S_BAND: begin
                if (i_sts.out_of_band) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = pdp_pkg::OP_VMIN;
                    n_state         = S_MIN_WT;
                end
            end
            S_MIN_WT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_MAX_GO;
                end
            end
            S_MAX_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = pdp_pkg::OP_VMAX;
                n_state         = S_MAX_WT;
            end
            S_MAX_WT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_last) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (i_sts.no_fit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_vco = 1'b1;
                    n_state       = S_NINT_GO;
                end
            end
            S_NINT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = pdp_pkg::OP_NINT;
                n_state         = S_NINT_WT;
            end
            S_NINT_WT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_OVF;
                end
            end
            S_OVF: begin
                if (i_sts.nint_ovf) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_frac = 1'b1;
                    n_state        = S_FRAC_GO;
                end
            end
            S_FRAC_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = pdp_pkg::OP_FRAC;
                n_state         = S_FRAC_WT;
            end
            S_FRAC_WT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_out_full || i_out_ready) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: tb/pll_divider_planner_test.sv
// ----------------------------------------------------------------------------
// pll_divider_planner_test: self-checking bench for the PLL divider planner
// Drives frequency requests under varied register settings, predicts each
// plan with exact integer arithmetic and compares every result field. The
// run mixes directed band-edge and corner requests with random traffic
// under several patterns of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module pll_divider_planner_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 3000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 205;

    typedef struct packed {
        pdp_pkg::t_status           status;
        logic [pdp_pkg::NINT_W-1:0] n_integer;
        logic [pdp_pkg::DEN_W-1:0]  n_fraction;
        logic                       prediv_code;
        logic [1:0]                 chdiv1_code;
        logic [2:0]                 chdiv2_code;
    } t_plan;

    class plan_board;
        logic [pdp_pkg::PFD_W-1:0] tx_pfd;
        logic [pdp_pkg::PFD_W-1:0] rx_pfd;
        logic                      tx_by4;
        logic                      rx_by4;
        logic [pdp_pkg::VCO_W-1:0] vco_lo;
        logic [pdp_pkg::VCO_W-1:0] vco_hi;
        logic [pdp_pkg::DEN_W-1:0] frac_den;
        t_plan                     due[$];
        int                        errors;

        function new();
            tx_pfd   = pdp_pkg::RST_TX_PFD;
            rx_pfd   = pdp_pkg::RST_RX_PFD;
            tx_by4   = pdp_pkg::RST_TX_BY4;
            rx_by4   = pdp_pkg::RST_RX_BY4;
            vco_lo   = pdp_pkg::RST_VCO_MIN;
            vco_hi   = pdp_pkg::RST_VCO_MAX;
            frac_den = pdp_pkg::RST_FRAC_DEN;
            errors   = 0;
        endfunction

        function void write_reg(logic [pdp_pkg::CFG_IDX_W-1:0] idx,
                                logic [pdp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pdp_pkg::REG_TX_PFD:   tx_pfd   = data[pdp_pkg::PFD_W-1:0];
                pdp_pkg::REG_RX_PFD:   rx_pfd   = data[pdp_pkg::PFD_W-1:0];
                pdp_pkg::REG_TX_BY4:   tx_by4   = data[0];
                pdp_pkg::REG_RX_BY4:   rx_by4   = data[0];
                pdp_pkg::REG_VCO_MIN:  vco_lo   = data;
                pdp_pkg::REG_VCO_MAX:  vco_hi   = data;
                pdp_pkg::REG_FRAC_DEN: frac_den = data[pdp_pkg::DEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_request(logic rx, logic [pdp_pkg::FREQ_W-1:0] freq);
            t_plan       p;
            logic [63:0] f, lo, hi, minc, maxc, best, c, pfd, d, vco, nint, frac;
            logic        by4;
            int          c1, k;
            p  = '0;
            f  = 64'(freq);
            lo = rx ? 64'(pdp_pkg::RX_BAND_LO) : 64'(pdp_pkg::TX_BAND_LO);
            hi = rx ? 64'(pdp_pkg::RX_BAND_HI) : 64'(pdp_pkg::TX_BAND_HI);
            if (f < lo || f > hi) begin
                p.status = pdp_pkg::ST_BAND;
            end else begin
                minc = (64'(vco_lo) + f - 64'd1) / f;
                maxc = 64'(vco_hi) / f;
                best = 64'd0;
                for (c1 = 4; c1 <= 7; c1++) begin
                    for (k = 0; k <= 6; k++) begin
                        c = 64'(c1) << k;
                        if (c >= minc && c <= maxc && c > best) begin
                            best = c;
                            p.chdiv1_code = 2'(c1 - 4);
                            p.chdiv2_code = 3'(k);
                        end
                    end
                end
                if (best == 64'd0) begin
                    p.status = pdp_pkg::ST_NOFIT;
                end else begin
                    pfd = rx ? 64'(rx_pfd) : 64'(tx_pfd);
                    if (pfd == 64'd0) begin
                        pfd = 64'd1;
                    end
                    by4  = rx ? rx_by4 : tx_by4;
                    d    = pfd * (by4 ? 64'd4 : 64'd2);
                    vco  = f * best;
                    nint = vco / d;
                    frac = ((vco % d) * 64'(frac_den)) / d;
                    p.prediv_code = by4;
                    if (nint > 64'(pdp_pkg::N_INT_MAX)) begin
                        p.status    = pdp_pkg::ST_OVF;
                        p.n_integer = pdp_pkg::N_INT_MAX;
                    end else begin
                        p.status     = pdp_pkg::ST_OK;
                        p.n_integer  = nint[pdp_pkg::NINT_W-1:0];
                        p.n_fraction = frac[pdp_pkg::DEN_W-1:0];
                    end
                end
            end
            due.push_back(p);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(t_plan got);
            t_plan want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            want = due.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("n_integer", 64'(want.n_integer), 64'(got.n_integer));
            compare_field("n_fraction", 64'(want.n_fraction), 64'(got.n_fraction));
            compare_field("prediv_code", 64'(want.prediv_code), 64'(got.prediv_code));
            compare_field("chdiv1_code", 64'(want.chdiv1_code), 64'(got.chdiv1_code));
            compare_field("chdiv2_code", 64'(want.chdiv2_code), 64'(got.chdiv2_code));
        endfunction
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    logic                           i_func      = 1'b0;
    logic [pdp_pkg::FREQ_W-1:0]     i_freq_hz   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [1:0]                     o_status;
    logic [pdp_pkg::NINT_W-1:0]     o_n_integer;
    logic [pdp_pkg::DEN_W-1:0]      o_n_fraction;
    logic                           o_prediv_code;
    logic [1:0]                     o_chdiv1_code;
    logic [2:0]                     o_chdiv2_code;
    logic                           i_cfg_we    = 1'b0;
    logic [pdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [pdp_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    plan_board board;
    int        cycles       = 0;
    int        idle_pct     = 0;
    int        stall_pct    = 0;
    int        hold_asks    = 0;
    int        holds_served = 0;
    int        hold_left    = 0;

    pll_divider_planner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_freq_hz     (i_freq_hz),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_n_integer   (o_n_integer),
        .o_n_fraction  (o_n_fraction),
        .o_prediv_code (o_prediv_code),
        .o_chdiv1_code (o_chdiv1_code),
        .o_chdiv2_code (o_chdiv2_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_plan seen;
        seen = {o_status, o_n_integer, o_n_fraction, o_prediv_code,
                o_chdiv1_code, o_chdiv2_code};
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                board.note_request(i_func, i_freq_hz);
            end
            if (o_out_valid && i_out_ready) begin
                board.check_result(seen);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_asks != holds_served) begin
            holds_served <= hold_asks;
            hold_left    <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer_request(input logic rx, input logic [pdp_pkg::FREQ_W-1:0] freq);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= rx;
        i_freq_hz  <= freq;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [pdp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pdp_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        board.write_reg(idx, data);
    endtask

    // Narrow registers get random upper bits to exercise the field masking.
    task automatic load_settings(input logic [pdp_pkg::PFD_W-1:0] tx_pfd,
                                 input logic [pdp_pkg::PFD_W-1:0] rx_pfd,
                                 input logic tx_by4, input logic rx_by4,
                                 input logic [pdp_pkg::VCO_W-1:0] vco_lo,
                                 input logic [pdp_pkg::VCO_W-1:0] vco_hi,
                                 input logic [pdp_pkg::DEN_W-1:0] frac_den);
        write_reg(pdp_pkg::REG_TX_PFD, {5'($urandom), tx_pfd});
        write_reg(pdp_pkg::REG_RX_PFD, {5'($urandom), rx_pfd});
        write_reg(pdp_pkg::REG_TX_BY4, {32'($urandom), tx_by4});
        write_reg(pdp_pkg::REG_RX_BY4, {32'($urandom), rx_by4});
        write_reg(pdp_pkg::REG_VCO_MIN, vco_lo);
        write_reg(pdp_pkg::REG_VCO_MAX, vco_hi);
        write_reg(pdp_pkg::REG_FRAC_DEN, {9'($urandom), frac_den});
        write_reg(pdp_pkg::CFG_IDX_W'(7), {1'($urandom), 32'($urandom)});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int items);
        logic                       rx;
        logic [pdp_pkg::FREQ_W-1:0] lo, hi, f;
        int                         sel;
        for (int n = 0; n < items; n++) begin
            rx  = 1'($urandom);
            lo  = rx ? pdp_pkg::RX_BAND_LO : pdp_pkg::TX_BAND_LO;
            hi  = rx ? pdp_pkg::RX_BAND_HI : pdp_pkg::TX_BAND_HI;
            sel = $urandom_range(99);
            if (sel < 75) begin
                f = $urandom_range(hi, lo);
            end else if (sel < 88) begin
                f = (sel[0] ? lo : hi) + pdp_pkg::FREQ_W'($urandom_range(2)) - 1;
            end else begin
                f = $urandom;
            end
            offer_request(rx, f);
        end
    endtask

    task automatic realistic_settings;
        logic [pdp_pkg::VCO_W-1:0] vco_lo;
        vco_lo = 33'd3000000000 + 33'($urandom_range(1500000000));
        load_settings(pdp_pkg::PFD_W'($urandom_range(100000000, 5000000)),
                      pdp_pkg::PFD_W'($urandom_range(100000000, 5000000)),
                      1'($urandom), 1'($urandom), vco_lo,
                      vco_lo + 33'd300000000 + 33'($urandom_range(2000000000)),
                      pdp_pkg::DEN_W'($urandom_range(16777215, 1)));
    endtask

    initial begin
        board = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        offer_request(1'b0, 32'd0);
        offer_request(1'b0, 32'd29999999);
        offer_request(1'b0, 32'd30000000);
        offer_request(1'b0, 32'd108000000);
        offer_request(1'b0, 32'd108000001);
        offer_request(1'b1, 32'd284999999);
        offer_request(1'b1, 32'd285000000);
        offer_request(1'b1, 32'd363000000);
        offer_request(1'b1, 32'd363000001);
        offer_request(1'b1, 32'hFFFFFFFF);
        offer_request(1'b0, 32'hFFFFFFFF);
        offer_request(1'b0, 32'd77777777);
        offer_request(1'b1, 32'd300000001);
        drain_results();

        // Zero transmit PFD acts as 1 Hz and overflows N; zero denominator.
        load_settings('0, '1, pdp_pkg::RST_TX_BY4, pdp_pkg::RST_RX_BY4,
                      pdp_pkg::RST_VCO_MIN, pdp_pkg::RST_VCO_MAX, '0);
        offer_request(1'b0, 32'd50000000);
        offer_request(1'b0, 32'd108000000);
        offer_request(1'b1, 32'd285000000);
        offer_request(1'b1, 32'd363000000);
        drain_results();

        // Inverted oscillator range leaves no divider; then a single-point range.
        load_settings(pdp_pkg::RST_TX_PFD, pdp_pkg::RST_RX_PFD, 1'b0, 1'b1, '1, 33'd1,
                      pdp_pkg::RST_FRAC_DEN);
        offer_request(1'b0, 32'd30000000);
        offer_request(1'b1, 32'd363000000);
        drain_results();
        load_settings(pdp_pkg::RST_TX_PFD, pdp_pkg::RST_RX_PFD, 1'b0, 1'b1,
                      33'd4800000000, 33'd4800000000, '1);
        offer_request(1'b0, 32'd30000000);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            case (p)
                0: load_settings(pdp_pkg::RST_TX_PFD, pdp_pkg::RST_RX_PFD,
                                 pdp_pkg::RST_TX_BY4, pdp_pkg::RST_RX_BY4,
                                 pdp_pkg::RST_VCO_MIN, pdp_pkg::RST_VCO_MAX,
                                 pdp_pkg::RST_FRAC_DEN);
                2: load_settings('1, '1, 1'b1, 1'b0, 33'd1, '1, '1);
                4: load_settings(pdp_pkg::PFD_W'($urandom_range(2000, 1)),
                                 pdp_pkg::PFD_W'($urandom_range(2000, 1)),
                                 1'($urandom), 1'($urandom),
                                 pdp_pkg::RST_VCO_MIN, pdp_pkg::RST_VCO_MAX,
                                 pdp_pkg::DEN_W'($urandom_range(16777215, 1)));
                6: load_settings(pdp_pkg::PFD_W'($urandom_range(3)),
                                 pdp_pkg::PFD_W'($urandom),
                                 1'($urandom), 1'($urandom),
                                 {1'($urandom), 32'($urandom)}, {1'($urandom), 32'($urandom)},
                                 pdp_pkg::DEN_W'($urandom));
                default: realistic_settings();
            endcase
            if (p == 1 || p == 5) begin
                hold_asks++;
            end
            run_random(PHASE_ITEMS);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
